### design/gtbp_pkg.sv
package gtbp_pkg;

	localparam int GROUP_SLOTS_DEF       = 16;
	localparam int MEMBERS_PER_GROUP_DEF = 32;
	localparam int TICKS_PER_SECOND_DEF  = 100;

	localparam logic [2:0] CMD_CHECK     = 3'd0;
	localparam logic [2:0] CMD_ATTACH    = 3'd1;
	localparam logic [2:0] CMD_DETACH    = 3'd2;
	localparam logic [2:0] CMD_SET_LIMIT = 3'd3;
	localparam logic [2:0] CMD_STATS     = 3'd4;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_THROTTLED = 2'd1;
	localparam logic [1:0] STATUS_REJECT    = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       idle;
		logic       next_slot;
		logic       scan_rd;
		logic       next_entry;
		logic       bkt_rd;
		logic       mul;
		logic       div_step;
		logic       upd;
		logic       attach_wr;
		logic       det_rd;
		logic       det_wr;
		logic       det_fin;
		logic       lim_wr;
		logic       stat_fill;
		logic       found;
		logic       set_status;
		logic [1:0] status;
		logic       post;
	} dp_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       accepted;
		logic [2:0] op;
		logic       grp_ok;
		logic       entry_ok;
		logic       last_slot;
		logic       hit;
		logic       lim_zero;
		logic       div_last;
		logic       cnt_full;
		logic       shift_more;
		logic       out_busy;
	} dp_st_t;

endpackage

### design/gtbp_if.sv
interface gtbp_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [14:0] pid;
	logic [3:0]  group;
	logic [1:0]  channel;
	logic [31:0] amount;
	logic [31:0] now;
	logic [31:0] rate_limit;

	modport source (output valid, cmd, pid, group, channel, amount, now, rate_limit,
		input ready);
	modport sink (input valid, cmd, pid, group, channel, amount, now, rate_limit,
		output ready);
endinterface

interface gtbp_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  matched_group;
	logic        group_matched;
	logic [63:0] byte_total;
	logic [31:0] op_total;
	logic [31:0] throttle_total;
	logic        throttled_mark;

	modport source (output valid, status, matched_group, group_matched, byte_total,
		op_total, throttle_total, throttled_mark, input ready);
	modport sink (input valid, status, matched_group, group_matched, byte_total,
		op_total, throttle_total, throttled_mark, output ready);
endinterface

### design/gtbp_ram.sv
module gtbp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### design/gtbp_datapath.sv
module gtbp_datapath import gtbp_pkg::*; #(
	parameter int GROUP_SLOTS       = GROUP_SLOTS_DEF,
	parameter int MEMBERS_PER_GROUP = MEMBERS_PER_GROUP_DEF,
	parameter int TICKS_PER_SECOND  = TICKS_PER_SECOND_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	gtbp_req_if.sink   req,
	gtbp_rsp_if.source rsp,
	input  dp_ctl_t    ctl,
	output dp_st_t     st
);
	localparam int SW  = $clog2(GROUP_SLOTS);
	localparam int MW  = (MEMBERS_PER_GROUP > 1) ? $clog2(MEMBERS_PER_GROUP) : 1;
	localparam int CW  = $clog2(MEMBERS_PER_GROUP + 1);
	localparam int NB  = GROUP_SLOTS * 4;
	localparam int NS  = GROUP_SLOTS * 2;
	localparam int MD  = GROUP_SLOTS * (2 ** MW);
	localparam int BKW = 160;
	localparam int LT    = $clog2(TICKS_PER_SECOND);
	localparam int SHIFT = 32 + 2 * LT;
	localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'(TICKS_PER_SECOND - 1)) /
		64'(TICKS_PER_SECOND);

	logic [2:0]  cmd_q;
	logic [14:0] pid_q;
	logic [3:0]  grp_q;
	logic [1:0]  ch_q;
	logic [31:0] amt_q, now_q, rate_q;

	logic [SW-1:0] slot_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] cnt_q [GROUP_SLOTS];

	logic [NB-1:0] lim_vld_q, bkt_vld_q;
	logic [NS-1:0] thr_vld_q, seen_q;
	logic          lv_q, bv_q, tv_q;

	logic [63:0]   quo_q;
	logic [127:0]  acc_q;
	logic [1:0]    dcnt_q;

	logic [1:0]  res_status_q;
	logic [3:0]  res_mg_q;
	logic        res_gm_q;
	logic [63:0] res_bytes_q;
	logic [31:0] res_ops_q, res_thr_q;
	logic        res_mark_q;
	logic        out_valid_q;

	logic            accept;
	logic [SW+3:0]   gx, sx;
	logic [CW-1:0]   cur_cnt;
	logic [CW:0]     idx_p1;
	logic [SW+1:0]   baddr;
	logic [SW:0]     saddr;

	logic                   m_we, m_re;
	logic [$clog2(MD)-1:0]  m_waddr, m_raddr;
	logic [14:0]            m_wdata, m_rdata;

	logic [31:0]    l_rdata, t_rdata, t_wdata;
	logic [BKW-1:0] b_rdata, b_wdata;

	logic [31:0]  lim, token, tick, reqs, ev, elapsed, cap32, new_tok;
	logic [31:0]  mul_a, mul_b, gain;
	logic [63:0]  bytes, prod;
	logic [127:0] pp_ext;
	logic [64:0]  lvl;
	logic         pass;
	logic         big;

	assign accept    = req.valid && req.ready;
	assign req.ready = ctl.idle;

	assign gx      = {{SW{1'b0}}, req.group};
	assign sx      = {4'd0, slot_q};
	assign cur_cnt = cnt_q[slot_q];
	assign idx_p1  = {1'b0, idx_q} + 1'b1;
	assign baddr   = {slot_q, ch_q};
	assign saddr   = {slot_q, ch_q[1]};

	// Member list store, searched one entry at a time.
	assign m_re    = ctl.scan_rd || ctl.det_rd;
	assign m_raddr = ctl.det_rd ? {slot_q, idx_p1[MW-1:0]} : {slot_q, idx_q[MW-1:0]};
	assign m_we    = ctl.attach_wr || ctl.det_wr;
	assign m_waddr = ctl.det_wr ? {slot_q, idx_q[MW-1:0]} : {slot_q, cur_cnt[MW-1:0]};
	assign m_wdata = ctl.det_wr ? m_rdata : pid_q;

	gtbp_ram #(.WIDTH(15), .DEPTH(MD)) u_member (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.re(m_re), .raddr(m_raddr), .rdata(m_rdata)
	);

	gtbp_ram #(.WIDTH(32), .DEPTH(NB)) u_limit (
		.clk(clk), .we(ctl.lim_wr && (rate_q != 32'd0)), .waddr(baddr), .wdata(rate_q),
		.re(ctl.bkt_rd), .raddr(baddr), .rdata(l_rdata)
	);

	gtbp_ram #(.WIDTH(BKW), .DEPTH(NB)) u_bucket (
		.clk(clk), .we(ctl.upd), .waddr(baddr), .wdata(b_wdata),
		.re(ctl.bkt_rd), .raddr(baddr), .rdata(b_rdata)
	);

	gtbp_ram #(.WIDTH(32), .DEPTH(NS)) u_throttle (
		.clk(clk), .we(ctl.upd && !pass), .waddr(saddr), .wdata(t_wdata),
		.re(ctl.bkt_rd), .raddr(saddr), .rdata(t_rdata)
	);

	// Entries never written read as zero.
	assign lim   = lv_q ? l_rdata : 32'd0;
	assign token = bv_q ? b_rdata[159:128] : 32'd0;
	assign tick  = bv_q ? b_rdata[127:96] : 32'd0;
	assign bytes = bv_q ? b_rdata[95:32] : 64'd0;
	assign reqs  = bv_q ? b_rdata[31:0] : 32'd0;
	assign ev    = tv_q ? t_rdata : 32'd0;

	assign elapsed = now_q - tick;

	// One multiplier forms elapsed * limit, then the four limb products of
	// that with the reciprocal of the tick rate, one per cycle.
	assign mul_a  = ctl.mul ? elapsed : (dcnt_q[1] ? quo_q[63:32] : quo_q[31:0]);
	assign mul_b  = ctl.mul ? lim : (dcnt_q[0] ? RECIP[63:32] : RECIP[31:0]);
	assign prod   = {32'd0, mul_a} * {32'd0, mul_b};
	assign pp_ext = (dcnt_q == 2'd0) ? {64'd0, prod} :
		(dcnt_q == 2'd3) ? {prod, 64'd0} : {32'd0, prod, 32'd0};

	// After a full second or more the bucket refills to its limit anyway;
	// below that the product stays small enough for the reciprocal to be exact.
	assign big  = elapsed >= 32'(TICKS_PER_SECOND);
	assign gain = big ? lim : acc_q[SHIFT +: 32];

	assign lvl     = {33'd0, token} + {33'd0, gain};
	assign cap32   = (lvl > {33'd0, lim}) ? lim : lvl[31:0];
	assign pass    = cap32 >= amt_q;
	assign new_tok = pass ? (cap32 - amt_q) : cap32;
	assign b_wdata = {new_tok, now_q, pass ? (bytes + {32'd0, amt_q}) : bytes,
		pass ? (reqs + 32'd1) : reqs};
	assign t_wdata = ev + 32'd1;

	always_comb begin
		st.accepted   = accept;
		st.op         = cmd_q;
		st.grp_ok     = {28'd0, grp_q} < 32'(GROUP_SLOTS);
		st.entry_ok   = idx_q < cur_cnt;
		st.last_slot  = slot_q == SW'(GROUP_SLOTS - 1);
		st.hit        = m_rdata == pid_q;
		st.lim_zero   = lim == 32'd0;
		st.div_last   = dcnt_q == 2'd3;
		st.cnt_full   = cur_cnt == CW'(MEMBERS_PER_GROUP);
		st.shift_more = idx_p1 < {1'b0, cur_cnt};
		st.out_busy   = out_valid_q && !rsp.ready;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= req.cmd;
			pid_q  <= req.pid;
			grp_q  <= req.group;
			ch_q   <= req.channel;
			amt_q  <= req.amount;
			now_q  <= req.now;
			rate_q <= req.rate_limit;
		end
		if (ctl.bkt_rd) begin
			lv_q <= lim_vld_q[baddr];
			bv_q <= bkt_vld_q[baddr];
			tv_q <= thr_vld_q[saddr];
		end
		if (ctl.mul) begin
			quo_q  <= prod;
			acc_q  <= '0;
			dcnt_q <= '0;
		end else if (ctl.div_step) begin
			acc_q  <= acc_q + pp_ext;
			dcnt_q <= dcnt_q + 2'd1;
		end
		if (accept) begin
			res_status_q <= STATUS_REJECT;
			res_mg_q     <= '0;
			res_gm_q     <= 1'b0;
			res_bytes_q  <= '0;
			res_ops_q    <= '0;
			res_thr_q    <= '0;
			res_mark_q   <= 1'b0;
		end else begin
			if (ctl.set_status) begin
				res_status_q <= ctl.status;
			end else if (ctl.upd) begin
				res_status_q <= pass ? STATUS_OK : STATUS_THROTTLED;
			end
			if (ctl.found) begin
				res_mg_q <= sx[3:0];
				res_gm_q <= 1'b1;
			end
			if (ctl.stat_fill) begin
				res_bytes_q <= bytes;
				res_ops_q   <= reqs;
				res_thr_q   <= ev;
				res_mark_q  <= seen_q[saddr];
			end
		end
		if (ctl.post) begin
			rsp.status         <= res_status_q;
			rsp.matched_group  <= res_mg_q;
			rsp.group_matched  <= res_gm_q;
			rsp.byte_total     <= res_bytes_q;
			rsp.op_total       <= res_ops_q;
			rsp.throttle_total <= res_thr_q;
			rsp.throttled_mark <= res_mark_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			idx_q       <= '0;
			lim_vld_q   <= '0;
			bkt_vld_q   <= '0;
			thr_vld_q   <= '0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < GROUP_SLOTS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (accept) begin
				slot_q <= (req.cmd == CMD_CHECK) ? '0 : gx[SW-1:0];
				idx_q  <= '0;
			end else if (ctl.next_slot) begin
				slot_q <= slot_q + 1'b1;
				idx_q  <= '0;
			end else if (ctl.next_entry || ctl.det_wr) begin
				idx_q <= idx_q + 1'b1;
			end
			if (ctl.attach_wr) begin
				cnt_q[slot_q] <= cur_cnt + 1'b1;
			end else if (ctl.det_fin) begin
				cnt_q[slot_q] <= cur_cnt - 1'b1;
			end
			if (ctl.lim_wr && (rate_q != 32'd0)) begin
				lim_vld_q[baddr] <= 1'b1;
			end
			if (ctl.upd) begin
				bkt_vld_q[baddr] <= 1'b1;
				if (!pass) begin
					thr_vld_q[saddr] <= 1'b1;
					seen_q[saddr]    <= 1'b1;
				end
			end
			if (ctl.post) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid = out_valid_q;
endmodule

### design/gtbp_ctrl.sv
module gtbp_ctrl import gtbp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  dp_st_t  st,
	output dp_ctl_t ctl
);
	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CMP, S_BKT_RD, S_BKT_EVAL, S_MUL,
		S_DIV, S_UPD, S_ATTACH, S_DET_RD, S_DET_WR, S_STAT_OUT, S_DONE
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				ctl.idle = 1'b1;
				if (st.accepted) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				ctl.set_status = 1'b1;
				ctl.status     = STATUS_REJECT;
				if (st.op == CMD_CHECK) begin
					ctl.status = STATUS_OK;
					state_d    = S_SCAN_RD;
				end else if (!st.grp_ok || st.op > CMD_STATS) begin
					state_d = S_DONE;
				end else if (st.op == CMD_SET_LIMIT) begin
					ctl.lim_wr = 1'b1;
					ctl.status = STATUS_OK;
					state_d    = S_DONE;
				end else if (st.op == CMD_STATS) begin
					ctl.bkt_rd = 1'b1;
					state_d    = S_STAT_OUT;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				if (st.entry_ok) begin
					ctl.scan_rd = 1'b1;
					state_d     = S_SCAN_CMP;
				end else if (st.op == CMD_CHECK && !st.last_slot) begin
					ctl.next_slot = 1'b1;
				end else if (st.op == CMD_ATTACH) begin
					state_d = S_ATTACH;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SCAN_CMP: begin
				if (!st.hit) begin
					ctl.next_entry = 1'b1;
					state_d        = S_SCAN_RD;
				end else if (st.op == CMD_CHECK) begin
					ctl.found  = 1'b1;
					ctl.bkt_rd = 1'b1;
					state_d    = S_BKT_EVAL;
				end else if (st.op == CMD_ATTACH) begin
					ctl.set_status = 1'b1;
					ctl.status     = STATUS_OK;
					state_d        = S_DONE;
				end else begin
					state_d = S_DET_RD;
				end
			end
			S_BKT_RD: begin
				ctl.bkt_rd = 1'b1;
				state_d    = S_BKT_EVAL;
			end
			S_BKT_EVAL: begin
				state_d = st.lim_zero ? S_DONE : S_MUL;
			end
			S_MUL: begin
				ctl.mul = 1'b1;
				state_d = S_DIV;
			end
			// Four limb products with the reciprocal of the tick rate.
			S_DIV: begin
				ctl.div_step = 1'b1;
				if (st.div_last) begin
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				ctl.upd = 1'b1;
				state_d = S_DONE;
			end
			S_ATTACH: begin
				if (!st.cnt_full) begin
					ctl.attach_wr  = 1'b1;
					ctl.set_status = 1'b1;
					ctl.status     = STATUS_OK;
				end
				state_d = S_DONE;
			end
			S_DET_RD: begin
				if (st.shift_more) begin
					ctl.det_rd = 1'b1;
					state_d    = S_DET_WR;
				end else begin
					ctl.det_fin    = 1'b1;
					ctl.set_status = 1'b1;
					ctl.status     = STATUS_OK;
					state_d        = S_DONE;
				end
			end
			S_DET_WR: begin
				ctl.det_wr = 1'b1;
				state_d    = S_DET_RD;
			end
			S_STAT_OUT: begin
				ctl.stat_fill  = 1'b1;
				ctl.set_status = 1'b1;
				ctl.status     = STATUS_OK;
				state_d        = S_DONE;
			end
			S_DONE: begin
				if (!st.out_busy) begin
					ctl.post = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

### design/group_token_bucket_policer_core.sv
// Group token-bucket policer. Requests arrive as words on req (valid/ready)
// and every word gives exactly one result word on rsp (valid/ready).
// A word is taken only while the controller is idle, so one word is in work
// at a time; its result sits in an output register while the next word is
// already accepted and worked on.
// A check compares the members of each slot in turn, reading and then
// comparing each member, and passes over each slot that holds no match;
// when the matched bucket has a limit it then takes a multiply step, the
// steps of multiplying by the reciprocal of the tick rate and an update
// step. Attach and detach scan one slot; a detach then moves the later
// members up, reading and writing each entry. Set limit and a statistics
// read take no scan.
// Reset clears all counts, limits, buckets and statistics at once through
// valid bits; no clearing pass is needed and req is ready straight away.
// If the receiver stalls rsp, a finished result waits in its register and
// the following word completes its work but is held until rsp drains.
module group_token_bucket_policer_core import gtbp_pkg::*; #(
	parameter int GROUP_SLOTS       = GROUP_SLOTS_DEF,
	parameter int MEMBERS_PER_GROUP = MEMBERS_PER_GROUP_DEF,
	parameter int TICKS_PER_SECOND  = TICKS_PER_SECOND_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	gtbp_req_if.sink   req,
	gtbp_rsp_if.source rsp
);
	dp_ctl_t ctl;
	dp_st_t  st;

	gtbp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .st(st), .ctl(ctl)
	);

	gtbp_datapath #(
		.GROUP_SLOTS(GROUP_SLOTS),
		.MEMBERS_PER_GROUP(MEMBERS_PER_GROUP),
		.TICKS_PER_SECOND(TICKS_PER_SECOND)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .ctl(ctl), .st(st)
	);

	// Only one word is in work: nothing is taken in the cycle after a take.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("word accepted while another is in work");

	// A throttle can only come from a matched group.
	a_thr_matched: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == STATUS_THROTTLED) |-> rsp.group_matched)
		else $error("throttled result without a matched group");

	// Statistics never travel with a check result.
	a_stats_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.group_matched) |-> (rsp.op_total == 32'd0 &&
		rsp.byte_total == 64'd0 && !rsp.throttled_mark))
		else $error("statistics fields set on a check result");
endmodule

### bench/tb.sv
module tb import gtbp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS     = GROUP_SLOTS_DEF;
	localparam int MEMBERS   = MEMBERS_PER_GROUP_DEF;
	localparam int TICK_RATE = TICKS_PER_SECOND_DEF;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [2:0]  cmd;
		logic [14:0] pid;
		logic [3:0]  group;
		logic [1:0]  channel;
		logic [31:0] amount;
		logic [31:0] now;
		logic [31:0] rate_limit;
	} policer_word_t;

	typedef struct {
		logic [1:0]  status;
		logic [3:0]  matched_group;
		logic        group_matched;
		logic [63:0] byte_total;
		logic [31:0] op_total;
		logic [31:0] throttle_total;
		logic        throttled_mark;
	} verdict_t;

	logic clk;
	logic arst_n;

	gtbp_req_if req_if();
	gtbp_rsp_if rsp_if();

	group_token_bucket_policer_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	// Shadow state of the policer.
	logic [14:0] member_pid [SLOTS][MEMBERS];
	int unsigned member_cnt [SLOTS];
	logic [31:0] bucket_limit [SLOTS*4];
	logic [31:0] bucket_tokens [SLOTS*4];
	logic [31:0] bucket_tick [SLOTS*4];
	logic [63:0] passed_bytes [SLOTS*4];
	logic [31:0] passed_ops [SLOTS*4];
	logic [31:0] side_throttles [SLOTS*2];
	logic        side_marked [SLOTS*2];

	verdict_t    pending_verdicts [$];
	int          gap_pct;
	int          stall_pct;
	int          mismatches;
	int          words_sent;
	int          verdicts_seen;
	int          checks_sent;
	int          throttles_seen;
	int          quiet_cycles;
	logic [31:0] tick_now;
	logic [14:0] pid_pool [20];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int find_member(int slot, logic [14:0] pid);
		for (int j = 0; j < member_cnt[slot]; j++)
			if (member_pid[slot][j] == pid)
				return j;
		return -1;
	endfunction

	function automatic verdict_t police(policer_word_t w);
		verdict_t    v;
		int          slot;
		int          pos;
		int          b;
		int          sd;
		logic [31:0] elapsed;
		logic [63:0] level;
		v = '{default: '0};
		v.status = STATUS_REJECT;
		b = w.group * 4 + w.channel;
		sd = w.group * 2 + w.channel[1];
		case (w.cmd)
			CMD_CHECK: begin
				v.status = STATUS_OK;
				slot = -1;
				for (int s = 0; s < SLOTS; s++)
					if (slot < 0 && find_member(s, w.pid) >= 0)
						slot = s;
				if (slot >= 0) begin
					b = slot * 4 + w.channel;
					sd = slot * 2 + w.channel[1];
					v.matched_group = slot[3:0];
					v.group_matched = 1'b1;
					if (bucket_limit[b] != 0) begin
						elapsed = w.now - bucket_tick[b];
						level = 64'(bucket_tokens[b]) +
							64'(elapsed) * 64'(bucket_limit[b]) / TICK_RATE;
						if (level > 64'(bucket_limit[b]))
							level = 64'(bucket_limit[b]);
						bucket_tick[b] = w.now;
						if (level >= 64'(w.amount)) begin
							bucket_tokens[b] = 32'(level - 64'(w.amount));
							passed_bytes[b] += 64'(w.amount);
							passed_ops[b] += 1;
						end else begin
							bucket_tokens[b] = level[31:0];
							side_marked[sd] = 1'b1;
							side_throttles[sd] += 1;
							v.status = STATUS_THROTTLED;
						end
					end
				end
			end
			CMD_ATTACH: begin
				if (find_member(w.group, w.pid) >= 0) begin
					v.status = STATUS_OK;
				end else if (member_cnt[w.group] < MEMBERS) begin
					member_pid[w.group][member_cnt[w.group]] = w.pid;
					member_cnt[w.group]++;
					v.status = STATUS_OK;
				end
			end
			CMD_DETACH: begin
				pos = find_member(w.group, w.pid);
				if (pos >= 0) begin
					for (int j = pos; j + 1 < member_cnt[w.group]; j++)
						member_pid[w.group][j] = member_pid[w.group][j+1];
					member_cnt[w.group]--;
					v.status = STATUS_OK;
				end
			end
			CMD_SET_LIMIT: begin
				if (w.rate_limit != 0)
					bucket_limit[b] = w.rate_limit;
				v.status = STATUS_OK;
			end
			CMD_STATS: begin
				v.status = STATUS_OK;
				v.byte_total = passed_bytes[b];
				v.op_total = passed_ops[b];
				v.throttle_total = side_throttles[sd];
				v.throttled_mark = side_marked[sd];
			end
			default: ;
		endcase
		return v;
	endfunction

	task automatic send_word(policer_word_t w);
		while ($urandom_range(99) < gap_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid      <= 1'b1;
		req_if.cmd        <= w.cmd;
		req_if.pid        <= w.pid;
		req_if.group      <= w.group;
		req_if.channel    <= w.channel;
		req_if.amount     <= w.amount;
		req_if.now        <= w.now;
		req_if.rate_limit <= w.rate_limit;
		do
			@(posedge clk);
		while (!req_if.ready);
		pending_verdicts.push_back(police(w));
		words_sent++;
		if (w.cmd == CMD_CHECK)
			checks_sent++;
	endtask

	task automatic send(logic [2:0] cmd, logic [14:0] pid, logic [3:0] group,
		logic [1:0] channel, logic [31:0] amount, logic [31:0] now, logic [31:0] rate);
		policer_word_t w;
		w = '{cmd, pid, group, channel, amount, now, rate};
		send_word(w);
	endtask

	task automatic report(string field, logic [63:0] expected, logic [63:0] actual);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s in result %0d: expected %0h, got %0h",
				field, verdicts_seen, expected, actual);
	endtask

	// Result checking and the receiver's stalls.
	always @(posedge clk) begin
		verdict_t e;
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			verdicts_seen++;
			if (pending_verdicts.size() == 0) begin
				report("unexpected word", 0, 1);
			end else begin
				e = pending_verdicts.pop_front();
				if (rsp_if.status == STATUS_THROTTLED)
					throttles_seen++;
				if (rsp_if.status !== e.status)
					report("status", e.status, rsp_if.status);
				if (rsp_if.matched_group !== e.matched_group)
					report("matched_group", e.matched_group, rsp_if.matched_group);
				if (rsp_if.group_matched !== e.group_matched)
					report("group_matched", e.group_matched, rsp_if.group_matched);
				if (rsp_if.byte_total !== e.byte_total)
					report("byte_total", e.byte_total, rsp_if.byte_total);
				if (rsp_if.op_total !== e.op_total)
					report("op_total", e.op_total, rsp_if.op_total);
				if (rsp_if.throttle_total !== e.throttle_total)
					report("throttle_total", e.throttle_total, rsp_if.throttle_total);
				if (rsp_if.throttled_mark !== e.throttled_mark)
					report("throttled_mark", e.throttled_mark, rsp_if.throttled_mark);
			end
		end
		rsp_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	task automatic test_directed();
		send(3'd5, 15'd0, 4'd0, 2'd0, 32'd0, 32'd0, 32'd0);
		send(3'd6, 15'h7FFF, 4'd15, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(3'd7, 15'd3, 4'd2, 2'd1, 32'd1, 32'd1, 32'd1);
		send(CMD_CHECK, 15'd0, 4'd0, 2'd0, 32'd10, 32'd0, 32'd0);
		send(CMD_SET_LIMIT, 15'd0, 4'd0, 2'd0, 32'd0, 32'd0, 32'd1000);
		send(CMD_SET_LIMIT, 15'd0, 4'd0, 2'd0, 32'd0, 32'd0, 32'd0);
		send(CMD_ATTACH, 15'd0, 4'd0, 2'd0, 32'd0, 32'd0, 32'd0);
		send(CMD_ATTACH, 15'd0, 4'd0, 2'd0, 32'd0, 32'd0, 32'd0);
		send(CMD_ATTACH, 15'h7FFF, 4'd15, 2'd0, 32'd0, 32'd0, 32'd0);
		send(CMD_CHECK, 15'd0, 4'd0, 2'd1, 32'hFFFF_FFFF, 32'd5, 32'd0);
		send(CMD_CHECK, 15'd0, 4'd0, 2'd0, 32'd0, 32'd0, 32'd0);
		send(CMD_CHECK, 15'd0, 4'd0, 2'd0, 32'd500, 32'd10, 32'd0);
		send(CMD_CHECK, 15'd0, 4'd0, 2'd0, 32'd1000, 32'd1000, 32'd0);
		send(CMD_STATS, 15'd0, 4'd0, 2'd0, 32'd0, 32'd0, 32'd0);
		send(CMD_SET_LIMIT, 15'd0, 4'd15, 2'd3, 32'd0, 32'd0, 32'hFFFF_FFFF);
		send(CMD_CHECK, 15'h7FFF, 4'd0, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'd0);
		// The tick count wraps between these two checks.
		send(CMD_CHECK, 15'h7FFF, 4'd0, 2'd3, 32'd1, 32'h10, 32'd0);
		// A lowered limit caps the tokens left over at the next check.
		send(CMD_SET_LIMIT, 15'd0, 4'd0, 2'd0, 32'd0, 32'd0, 32'd10);
		send(CMD_CHECK, 15'd0, 4'd0, 2'd0, 32'd11, 32'd5000, 32'd0);
		send(CMD_DETACH, 15'd5, 4'd0, 2'd0, 32'd0, 32'd0, 32'd0);
		send(CMD_ATTACH, 15'd1, 4'd0, 2'd0, 32'd0, 32'd0, 32'd0);
		send(CMD_DETACH, 15'd0, 4'd0, 2'd0, 32'd0, 32'd0, 32'd0);
		send(CMD_CHECK, 15'd1, 4'd0, 2'd0, 32'd3, 32'd5100, 32'd0);
		send(CMD_STATS, 15'd0, 4'd15, 2'd3, 32'd0, 32'd0, 32'd0);
		send(CMD_STATS, 15'd0, 4'd0, 2'd2, 32'd0, 32'd0, 32'd0);
	endtask

	task automatic test_full_slot();
		for (int i = 0; i <= MEMBERS; i++)
			send(CMD_ATTACH, 15'(16'h4000 + i), 4'd7, 2'd0, 32'd0, 32'd0, 32'd0);
		send(CMD_DETACH, 15'h4003, 4'd7, 2'd0, 32'd0, 32'd0, 32'd0);
		send(CMD_CHECK, 15'(16'h4000 + MEMBERS - 1), 4'd0, 2'd2, 32'd7, 32'd6000, 32'd0);
	endtask

	task automatic test_random(int count);
		policer_word_t w;
		int            pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			w.cmd = pick < 40 ? CMD_CHECK : pick < 58 ? CMD_ATTACH : pick < 66 ? CMD_DETACH :
				pick < 78 ? CMD_SET_LIMIT : pick < 95 ? CMD_STATS : 3'($urandom_range(5, 7));
			w.pid = ($urandom_range(9) != 0) ? pid_pool[$urandom_range(19)] : 15'($urandom);
			w.group = 4'($urandom);
			w.channel = 2'($urandom);
			pick = $urandom_range(9);
			w.amount = pick < 7 ? 32'($urandom_range(0, 3000)) : pick == 7 ? 32'd0 :
				pick == 8 ? 32'hFFFF_FFFF : 32'($urandom);
			if ($urandom_range(49) == 0)
				tick_now = $urandom;
			else
				tick_now += $urandom_range(0, 60);
			w.now = tick_now;
			pick = $urandom_range(9);
			w.rate_limit = pick < 5 ? 32'($urandom_range(1, 5000)) : pick < 7 ? 32'd0 :
				32'($urandom);
			send_word(w);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.cmd = CMD_CHECK;
		req_if.pid = '0;
		req_if.group = '0;
		req_if.channel = '0;
		req_if.amount = '0;
		req_if.now = '0;
		req_if.rate_limit = '0;
		rsp_if.ready = 1'b0;
		gap_pct = 11;
		stall_pct = 54;
		mismatches = 0;
		words_sent = 0;
		verdicts_seen = 0;
		checks_sent = 0;
		throttles_seen = 0;
		quiet_cycles = 0;
		tick_now = 32'd7000;
		for (int s = 0; s < SLOTS; s++)
			member_cnt[s] = 0;
		for (int b = 0; b < SLOTS*4; b++) begin
			bucket_limit[b] = '0;
			bucket_tokens[b] = '0;
			bucket_tick[b] = '0;
			passed_bytes[b] = '0;
			passed_ops[b] = '0;
		end
		for (int d = 0; d < SLOTS*2; d++) begin
			side_throttles[d] = '0;
			side_marked[d] = 1'b0;
		end
		pid_pool[0] = 15'd0;
		pid_pool[1] = 15'h7FFF;
		pid_pool[2] = 15'h5555;
		pid_pool[3] = 15'h2AAA;
		for (int i = 4; i < 20; i++)
			pid_pool[i] = 15'($urandom);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_slot();
		test_random(530);
		gap_pct = 54;
		stall_pct = 11;
		test_random(530);
		gap_pct = 0;
		stall_pct = 0;
		test_random(530);

		@(posedge clk);
		req_if.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		$display("Sent %0d words (%0d checks); %0d results came back, %0d of them throttled.",
			words_sent, checks_sent, verdicts_seen, throttles_seen);
		$display("Mismatching fields: %0d.", mismatches);
		if (mismatches == 0 && pending_verdicts.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

### filelist.f
design/gtbp_pkg.sv
design/gtbp_if.sv
design/gtbp_ram.sv
design/gtbp_datapath.sv
design/gtbp_ctrl.sv
design/group_token_bucket_policer_core.sv
bench/tb.sv
